### src/ced_pkg.sv
package ced_pkg;

	localparam logic [7:0] CHAR_CARET = 8'h5E;
	localparam logic [7:0] CHAR_X_LO  = 8'h78;
	localparam logic [7:0] CHAR_X_UP  = 8'h58;
	localparam logic [7:0] CHAR_D0    = 8'h30;
	localparam logic [7:0] CHAR_D9    = 8'h39;
	localparam logic [7:0] CHAR_A_LO  = 8'h61;
	localparam logic [7:0] CHAR_F_LO  = 8'h66;
	localparam logic [7:0] CHAR_A_UP  = 8'h41;
	localparam logic [7:0] CHAR_F_UP  = 8'h46;

	// Palette levels as 16-bit fixed point, 65535 being full scale.
	localparam logic [15:0] Q_ONE = 16'd65535;
	localparam logic [15:0] Q_0P6 = 16'd39321;
	localparam logic [15:0] Q_0P5 = 16'd32768;
	localparam logic [15:0] Q_0P4 = 16'd26214;
	localparam logic [15:0] Q_0P3 = 16'd19661;
	localparam logic [15:0] Q_ZERO = 16'd0;

	typedef enum logic [1:0] {
		KIND_NONE    = 2'd0,
		KIND_PALETTE = 2'd1,
		KIND_HEX     = 2'd2
	} kind_t;

	typedef struct packed {
		logic [15:0] blue;
		logic [15:0] green;
		logic [15:0] red;
	} rgb_t;

	typedef struct packed {
		rgb_t  rgb;
		kind_t kind;
	} color_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] value;
	} nibble_t;

	function automatic rgb_t palette_lookup(input logic [3:0] idx);
		rgb_t c;
		unique case (idx)
			4'd0: c = '{red: Q_ZERO, green: Q_ZERO, blue: Q_ZERO};
			4'd1: c = '{red: Q_ONE,  green: Q_0P3,  blue: Q_0P3};
			4'd2: c = '{red: Q_0P3,  green: Q_ONE,  blue: Q_0P3};
			4'd3: c = '{red: Q_0P5,  green: Q_0P5,  blue: Q_ONE};
			4'd4: c = '{red: Q_ONE,  green: Q_ONE,  blue: Q_0P3};
			4'd5: c = '{red: Q_ONE,  green: Q_0P3,  blue: Q_ONE};
			4'd6: c = '{red: Q_0P3,  green: Q_ONE,  blue: Q_ONE};
			4'd7: c = '{red: Q_ONE,  green: Q_ONE,  blue: Q_ONE};
			4'd8: c = '{red: Q_0P6,  green: Q_0P6,  blue: Q_0P6};
			4'd9: c = '{red: Q_0P4,  green: Q_0P4,  blue: Q_0P4};
			default: c = '{red: Q_ZERO, green: Q_ZERO, blue: Q_ZERO};
		endcase
		return c;
	endfunction

endpackage

### src/ced_hex_nibble.sv
module ced_hex_nibble (
	input  logic [7:0]       char_in,
	output ced_pkg::nibble_t nibble
);

	logic is_digit;
	logic is_lower;
	logic is_upper;

	assign is_digit = (char_in >= ced_pkg::CHAR_D0)   && (char_in <= ced_pkg::CHAR_D9);
	assign is_lower = (char_in >= ced_pkg::CHAR_A_LO) && (char_in <= ced_pkg::CHAR_F_LO);
	assign is_upper = (char_in >= ced_pkg::CHAR_A_UP) && (char_in <= ced_pkg::CHAR_F_UP);

	// Both letter ranges start at a low nibble of 1, so adding nine gives ten.
	always_comb begin
		nibble.ok = is_digit || is_lower || is_upper;
		if (is_digit) begin
			nibble.value = char_in[3:0];
		end else begin
			nibble.value = char_in[3:0] + 4'd9;
		end
	end

endmodule

### src/ced_decode.sv
module ced_decode (
	input  logic [7:0]      chars [8],
	output ced_pkg::color_t color
);

	ced_pkg::nibble_t nib [6];
	logic             hex_ok;
	logic [7:0]       byte_r;
	logic [7:0]       byte_g;
	logic [7:0]       byte_b;

	for (genvar i = 0; i < 6; i++) begin : g_nib
		ced_hex_nibble u_nib (
			.char_in (chars[i + 2]),
			.nibble  (nib[i])
		);
	end

	assign hex_ok = nib[0].ok && nib[1].ok && nib[2].ok && nib[3].ok && nib[4].ok && nib[5].ok;
	assign byte_r = {nib[0].value, nib[1].value};
	assign byte_g = {nib[2].value, nib[3].value};
	assign byte_b = {nib[4].value, nib[5].value};

	// Scaling a byte by 257 is the same as repeating it in both halves.
	always_comb begin
		color.kind = ced_pkg::KIND_NONE;
		color.rgb  = '0;
		if (chars[0] == ced_pkg::CHAR_CARET) begin
			if ((chars[1] >= ced_pkg::CHAR_D0) && (chars[1] <= ced_pkg::CHAR_D9)) begin
				color.kind = ced_pkg::KIND_PALETTE;
				color.rgb  = ced_pkg::palette_lookup(chars[1][3:0]);
			end else if (((chars[1] == ced_pkg::CHAR_X_LO) || (chars[1] == ced_pkg::CHAR_X_UP))
					&& hex_ok) begin
				color.kind      = ced_pkg::KIND_HEX;
				color.rgb.red   = {byte_r, byte_r};
				color.rgb.green = {byte_g, byte_g};
				color.rgb.blue  = {byte_b, byte_b};
			end
		end
	end

endmodule

### src/color_escape_decoder.sv
// Color escape decoder. Each request on the input stream is an eight-byte text
// window (char0 in the lowest byte). The block answers with one result per
// request. The result's tuser carries escape_kind: 0 for no escape, 1 for a
// caret-digit palette escape, 2 for a caret-x six-digit hex escape. Its tdata
// carries red, green and blue as 16-bit fixed point where 65535 is full
// intensity, all zero when there is no escape. One request can be taken every
// clock cycle while the output accepts results. An accepted request is
// captured in the input register, and its combinational decode is captured
// in the result register when that register can advance. Backpressure on
// the output holds the result register. While a finished result waits, one
// more request is taken only if the input register is empty.
module color_escape_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // char0, char1, ..., char7 (8 bits each)
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // red(16), green(16), blue(16)
	output logic [1:0]  m_axis_tuser   // escape_kind(2)
);

	logic            valid_s1;
	logic [63:0]     data_s1;
	logic            valid_s2;
	ced_pkg::color_t color_s2;
	ced_pkg::color_t color_d;
	logic [7:0]      chars [8];
	logic            adv_s2;
	logic            adv_s1;

	assign adv_s2        = !valid_s2 || m_axis_tready;
	assign adv_s1        = !valid_s1 || adv_s2;
	assign s_axis_tready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && s_axis_tvalid) begin
			data_s1 <= s_axis_tdata;
		end
		if (adv_s2 && valid_s1) begin
			color_s2 <= color_d;
		end
	end

	for (genvar i = 0; i < 8; i++) begin : g_chars
		assign chars[i] = data_s1[8*i +: 8];
	end

	ced_decode u_decode (
		.chars (chars),
		.color (color_d)
	);

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {color_s2.rgb.blue, color_s2.rgb.green, color_s2.rgb.red};
	assign m_axis_tuser  = color_s2.kind;

	a_none_is_black: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && (color_s2.kind == ced_pkg::KIND_NONE)) |-> (color_s2.rgb == '0))
		else $error("no-escape result carries a nonzero color");

	a_hex_replicated: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && (color_s2.kind == ced_pkg::KIND_HEX)) |->
		((color_s2.rgb.red[15:8] == color_s2.rgb.red[7:0])
		&& (color_s2.rgb.green[15:8] == color_s2.rgb.green[7:0])
		&& (color_s2.rgb.blue[15:8] == color_s2.rgb.blue[7:0])))
		else $error("hex channel is not a byte scaled by 257");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> valid_s1)
		else $error("accepted request did not reach the input register");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s2) |=> (valid_s1 && $stable(data_s1)))
		else $error("input register changed while the result register stalled");

	a_s1_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv_s2) |=> valid_s2)
		else $error("decoded item was dropped between stages");

endmodule
